@@ rtl/core/orcc_pkg.sv @@
`timescale 1ns / 1ps

package orcc_pkg;

    // Fixed field widths of the command and result words.
    localparam int SEQ_BITS         = 64;
    localparam int GEN_BITS         = 64;
    localparam int DEVICE_PORT_BITS = 32;
    localparam int CFG_DATA_BITS    = 32;
    localparam int CFG_ADDR_BITS    = 1;

    // Default width of a device identifier inside the controller.
    localparam int DEVICE_ID_BITS_DEFAULT = 32;

    // Command codes.
    localparam logic [1:0] CMD_NOTIFY   = 2'd0;
    localparam logic [1:0] CMD_OUTCOME  = 2'd1;
    localparam logic [1:0] CMD_SHUTDOWN = 2'd2;
    localparam logic [1:0] CMD_INIT     = 2'd3;

    // Activation outcome codes.
    localparam logic [1:0] OUTC_ACTIVE    = 2'd0;
    localparam logic [1:0] OUTC_FAILED    = 2'd1;
    localparam logic [1:0] OUTC_LOST      = 2'd2;
    localparam logic [1:0] OUTC_NO_OUTPUT = 2'd3;

    // Status codes reported in each result word.
    localparam logic [3:0] ST_IGNORED    = 4'd0;
    localparam logic [3:0] ST_STALE      = 4'd1;
    localparam logic [3:0] ST_COALESCED  = 4'd2;
    localparam logic [3:0] ST_PENDING    = 4'd3;
    localparam logic [3:0] ST_COMMITTED  = 4'd4;
    localparam logic [3:0] ST_NO_CAND    = 4'd5;
    localparam logic [3:0] ST_CAND_STALE = 4'd6;
    localparam logic [3:0] ST_FAILED     = 4'd7;
    localparam logic [3:0] ST_LOST       = 4'd8;
    localparam logic [3:0] ST_NO_OUTPUT  = 4'd9;
    localparam logic [3:0] ST_DONE       = 4'd10;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INIT_VALID = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INIT_ID    = 1'b1;

    typedef struct packed {
        logic [1:0]                  command;
        logic [SEQ_BITS-1:0]         notify_seq;
        logic [DEVICE_PORT_BITS-1:0] event_device;
        logic                        event_is_removal;
        logic [1:0]                  outcome_code;
        logic [SEQ_BITS-1:0]         outcome_sequence;
        logic [DEVICE_PORT_BITS-1:0] outcome_device;
        logic                        old_resumed;
    } in_word_t;

    typedef struct packed {
        logic [3:0]                  status_code;
        logic [GEN_BITS-1:0]         generation;
        logic                        cand_valid;
        logic [SEQ_BITS-1:0]         cand_sequence;
        logic [DEVICE_PORT_BITS-1:0] cand_device;
        logic                        cand_removal;
        logic                        active_valid;
        logic [DEVICE_PORT_BITS-1:0] active_device;
        logic                        output_on;
        logic                        in_transition;
        logic [SEQ_BITS-1:0]         last_sequence;
        logic                        accepting;
    } out_word_t;

endpackage

@@ rtl/core/output_route_change_controller.sv @@
// Output route change controller.
// A result word is registered into the output buffer when its command word is accepted.
// Throughput: one command word per cycle while the skid entry is empty; a two-entry
// output buffer keeps the input side open while one finished result waits to be taken.
// Reset (aresetn low, synchronous): configuration and controller state, but for the
// payload registers, return to their startup values and the output buffer empties.
`timescale 1ns / 1ps

module output_route_change_controller
    import orcc_pkg::*;
#(
    parameter int DEVICE_ID_BITS = DEVICE_ID_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_word_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_word_t                m_data,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data
);

    // Device identifiers are kept at the narrower of the internal and port widths.
    localparam int DEV_W = (DEVICE_ID_BITS < DEVICE_PORT_BITS) ?
                           DEVICE_ID_BITS : DEVICE_PORT_BITS;

    // Configuration registers.
    logic             init_valid_reg;
    logic [DEV_W-1:0] init_dev_reg;

    // Controller state.
    logic                accept_reg, accept_next;
    logic                seen_reg, seen_next;
    logic [SEQ_BITS-1:0] last_seq_reg, last_seq_next;
    logic                active_reg, active_next;
    logic [DEV_W-1:0]    active_dev_reg, active_dev_next;
    logic                output_reg, output_next;
    logic                pend_reg, pend_next;
    logic [SEQ_BITS-1:0] pend_seq_reg, pend_seq_next;
    logic [DEV_W-1:0]    pend_dev_reg, pend_dev_next;
    logic                pend_removal_reg, pend_removal_next;
    logic                trans_reg, trans_next;
    logic [GEN_BITS-1:0] gen_reg, gen_next;

    // Output buffer: head word and skid word.
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      skid_valid_reg;
    out_word_t skid_word_reg;

    logic             push;
    logic             pop;
    logic [DEV_W-1:0] ev_dev;
    logic [DEV_W-1:0] oc_dev;
    out_word_t        result;

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign ev_dev  = s_data.event_device[DEV_W-1:0];
    assign oc_dev  = s_data.outcome_device[DEV_W-1:0];

    // Next state and result word for the command at the input.
    always_comb begin
        logic [3:0] status;
        logic       trans_out;
        logic       merge;
        logic       keep_old;

        accept_next       = accept_reg;
        seen_next         = seen_reg;
        last_seq_next     = last_seq_reg;
        active_next       = active_reg;
        active_dev_next   = active_dev_reg;
        output_next       = output_reg;
        pend_next         = pend_reg;
        pend_seq_next     = pend_seq_reg;
        pend_dev_next     = pend_dev_reg;
        pend_removal_next = pend_removal_reg;
        trans_next        = trans_reg;
        gen_next          = gen_reg;
        status            = ST_DONE;
        trans_out         = 1'b0;
        merge             = pend_reg && (pend_dev_reg == ev_dev) &&
                            !pend_removal_reg && !s_data.event_is_removal;
        keep_old          = s_data.old_resumed && active_reg;

        unique case (s_data.command)
            CMD_NOTIFY: begin
                if (!accept_reg) begin
                    status = ST_IGNORED;
                end else if (seen_reg && (s_data.notify_seq <= last_seq_reg)) begin
                    status = ST_STALE;
                end else begin
                    last_seq_next = s_data.notify_seq;
                    seen_next     = 1'b1;
                    if (active_reg && (ev_dev == active_dev_reg) &&
                        !s_data.event_is_removal) begin
                        // The event names the device already playing.
                        pend_next  = 1'b0;
                        trans_next = 1'b0;
                        status     = ST_COALESCED;
                    end else begin
                        pend_next         = 1'b1;
                        pend_seq_next     = s_data.notify_seq;
                        pend_dev_next     = ev_dev;
                        pend_removal_next = s_data.event_is_removal;
                        trans_next        = 1'b1;
                        status            = merge ? ST_COALESCED : ST_PENDING;
                    end
                end
                trans_out = trans_next;
            end
            CMD_OUTCOME: begin
                if (!accept_reg) begin
                    status = ST_IGNORED;
                end else if (!pend_reg) begin
                    status = ST_NO_CAND;
                end else begin
                    trans_out = 1'b1;
                    if ((pend_seq_reg != s_data.outcome_sequence) ||
                        (pend_dev_reg != oc_dev)) begin
                        status = ST_CAND_STALE;
                    end else begin
                        case (s_data.outcome_code)
                            OUTC_ACTIVE: begin
                                if (gen_reg == {GEN_BITS{1'b1}}) begin
                                    // Generation is exhausted: roll back, keep the flag.
                                    pend_next   = 1'b0;
                                    output_next = keep_old;
                                    active_next = keep_old;
                                    status      = ST_FAILED;
                                end else begin
                                    pend_next       = 1'b0;
                                    active_next     = 1'b1;
                                    active_dev_next = pend_dev_reg;
                                    output_next     = 1'b1;
                                    trans_next      = 1'b0;
                                    gen_next        = gen_reg + 1'b1;
                                    status          = ST_COMMITTED;
                                end
                            end
                            OUTC_FAILED: begin
                                pend_next   = 1'b0;
                                output_next = keep_old;
                                active_next = keep_old;
                                trans_next  = 1'b0;
                                status      = ST_FAILED;
                            end
                            OUTC_LOST: begin
                                pend_next   = 1'b0;
                                output_next = keep_old;
                                active_next = keep_old;
                                trans_next  = 1'b0;
                                status      = ST_LOST;
                            end
                            default: begin
                                pend_next   = 1'b0;
                                output_next = 1'b0;
                                active_next = 1'b0;
                                trans_next  = 1'b0;
                                status      = ST_NO_OUTPUT;
                            end
                        endcase
                    end
                end
            end
            CMD_SHUTDOWN: begin
                accept_next = 1'b0;
                pend_next   = 1'b0;
                trans_next  = 1'b0;
            end
            CMD_INIT: begin
                accept_next     = 1'b1;
                seen_next       = 1'b0;
                last_seq_next   = '0;
                active_next     = init_valid_reg;
                active_dev_next = init_dev_reg;
                output_next     = init_valid_reg;
                pend_next       = 1'b0;
                trans_next      = 1'b0;
                gen_next        = '0;
            end
        endcase

        // Snapshot of the state after the command; invalid entries read as zero.
        result               = '0;
        result.status_code   = status;
        result.generation    = gen_next;
        result.cand_valid    = pend_next;
        result.output_on     = output_next;
        result.in_transition = trans_out;
        result.last_sequence = last_seq_next;
        result.accepting     = accept_next;
        result.active_valid  = active_next;
        if (pend_next) begin
            result.cand_sequence             = pend_seq_next;
            result.cand_device[DEV_W-1:0]    = pend_dev_next;
            result.cand_removal              = pend_removal_next;
        end
        if (active_next) begin
            result.active_device[DEV_W-1:0] = active_dev_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_valid_reg <= 1'b0;
            init_dev_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_INIT_VALID: init_valid_reg <= cfg_wr_data[0];
                CFG_INIT_ID:    init_dev_reg   <= cfg_wr_data[DEV_W-1:0];
            endcase
        end
    end

    // Controller state update on each accepted command word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_reg     <= 1'b1;
            seen_reg       <= 1'b0;
            last_seq_reg   <= '0;
            active_reg     <= 1'b0;
            output_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            trans_reg      <= 1'b0;
            gen_reg        <= '0;
        end else if (push) begin
            accept_reg     <= accept_next;
            seen_reg       <= seen_next;
            last_seq_reg   <= last_seq_next;
            active_reg     <= active_next;
            output_reg     <= output_next;
            pend_reg       <= pend_next;
            trans_reg      <= trans_next;
            gen_reg        <= gen_next;
        end
    end

    // Payload parts of the state; they are only read while their flags are set.
    always_ff @(posedge aclk) begin
        if (push) begin
            active_dev_reg   <= active_dev_next;
            pend_seq_reg     <= pend_seq_next;
            pend_dev_reg     <= pend_dev_next;
            pend_removal_reg <= pend_removal_next;
        end
    end

    // Two-entry output buffer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer data.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_word_reg <= skid_word_reg;
                if (push) begin
                    skid_word_reg <= result;
                end
            end else if (push) begin
                out_word_reg <= result;
            end
        end else if (push) begin
            skid_word_reg <= result;
        end
    end

`ifndef NO_ASSERTIONS
    // A word accepted while the head waits must land in the skid entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("accepted word was not held in the skid entry");

    // The generation only steps by one, or returns to zero on init.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_reg != $past(gen_reg)) |->
            ((gen_reg == $past(gen_reg) + 1'b1) || (gen_reg == '0)))
        else $error("route generation moved by other than one step");

    // Without an accepted command the controller state holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(push) |-> ($stable(gen_reg) && $stable(last_seq_reg) &&
                          $stable(pend_reg) && $stable(accept_reg)))
        else $error("controller state changed without a command");

    // A result without a candidate reports zero candidate fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.cand_valid) |->
            ((m_data.cand_sequence == '0) && (m_data.cand_device == '0) &&
             !m_data.cand_removal))
        else $error("candidate fields not cleared while no candidate");
`endif

endmodule

@@ tb/route_state_checker.sv @@
`timescale 1ns / 1ps

module route_state_checker
    import orcc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_word_t                 s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_word_t                m_data,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    output int                       words_outstanding,
    output int                       mismatch_count
);

    // Mirror of the configuration registers.
    logic                        init_valid_q;
    logic [DEVICE_PORT_BITS-1:0] init_id_q;

    // Mirror of the controller state.
    logic                        accepting_q;
    logic                        seen_any_q;
    logic [SEQ_BITS-1:0]         last_seq_q;
    logic                        active_q;
    logic [DEVICE_PORT_BITS-1:0] active_dev_q;
    logic                        out_on_q;
    logic                        cand_q;
    logic [SEQ_BITS-1:0]         cand_seq_q;
    logic [DEVICE_PORT_BITS-1:0] cand_dev_q;
    logic                        cand_rm_q;
    logic                        trans_q;
    logic [GEN_BITS-1:0]         gen_q;

    out_word_t expected_words[$];
    int        err_total   = 0;
    int        words_taken = 0;

    // Startup values of the route state.
    function automatic void clear_route_state();
        accepting_q  = 1'b1;
        seen_any_q   = 1'b0;
        last_seq_q   = '0;
        active_q     = 1'b0;
        active_dev_q = '0;
        out_on_q     = 1'b0;
        cand_q       = 1'b0;
        cand_seq_q   = '0;
        cand_dev_q   = '0;
        cand_rm_q    = 1'b0;
        trans_q      = 1'b0;
        gen_q        = '0;
    endfunction

    // Drop the candidate; the old route survives only if it resumed and was active.
    function automatic void roll_back_route(logic resumed);
        cand_q   = 1'b0;
        out_on_q = resumed && active_q;
        if (!out_on_q) begin
            active_q     = 1'b0;
            active_dev_q = '0;
        end
    endfunction

    // Apply one command word to the mirrored state and build the result word.
    // Device identifiers are full port width at the default DEVICE_ID_BITS.
    function automatic out_word_t predict_route_word(in_word_t w);
        out_word_t  r;
        logic [3:0] st;
        logic       tr;
        logic       rm_active;
        logic       needs;
        logic       merge;
        st = ST_DONE;
        tr = 1'b0;
        case (w.command)
            CMD_NOTIFY: begin
                if (!accepting_q) begin
                    st = ST_IGNORED;
                end else if (seen_any_q && w.notify_seq <= last_seq_q) begin
                    st = ST_STALE;
                end else begin
                    last_seq_q = w.notify_seq;
                    seen_any_q = 1'b1;
                    rm_active  = w.event_is_removal && active_q &&
                                 w.event_device == active_dev_q;
                    needs      = !active_q || w.event_device != active_dev_q || rm_active;
                    if (!needs) begin
                        cand_q  = 1'b0;
                        trans_q = 1'b0;
                        st      = ST_COALESCED;
                    end else begin
                        // A repeat of a pending add for the same device is merged.
                        merge      = cand_q && cand_dev_q == w.event_device &&
                                     !cand_rm_q && !w.event_is_removal;
                        cand_q     = 1'b1;
                        cand_seq_q = w.notify_seq;
                        cand_dev_q = w.event_device;
                        cand_rm_q  = w.event_is_removal;
                        trans_q    = 1'b1;
                        st         = merge ? ST_COALESCED : ST_PENDING;
                    end
                end
                tr = trans_q;
            end
            CMD_OUTCOME: begin
                if (!accepting_q) begin
                    st = ST_IGNORED;
                end else if (!cand_q) begin
                    st = ST_NO_CAND;
                end else begin
                    tr = 1'b1;
                    if (cand_seq_q != w.outcome_sequence || cand_dev_q != w.outcome_device) begin
                        st = ST_CAND_STALE;
                    end else begin
                        case (w.outcome_code)
                            OUTC_ACTIVE: begin
                                // At the top generation a commit rolls back instead,
                                // and the stored transition flag is kept.
                                if (gen_q == '1) begin
                                    roll_back_route(w.old_resumed);
                                    st = ST_FAILED;
                                end else begin
                                    cand_q       = 1'b0;
                                    active_q     = 1'b1;
                                    active_dev_q = cand_dev_q;
                                    out_on_q     = 1'b1;
                                    trans_q      = 1'b0;
                                    gen_q        = gen_q + 1'b1;
                                    st           = ST_COMMITTED;
                                end
                            end
                            OUTC_FAILED: begin
                                roll_back_route(w.old_resumed);
                                trans_q = 1'b0;
                                st      = ST_FAILED;
                            end
                            OUTC_LOST: begin
                                roll_back_route(w.old_resumed);
                                trans_q = 1'b0;
                                st      = ST_LOST;
                            end
                            default: begin
                                cand_q       = 1'b0;
                                out_on_q     = 1'b0;
                                active_q     = 1'b0;
                                active_dev_q = '0;
                                trans_q      = 1'b0;
                                st           = ST_NO_OUTPUT;
                            end
                        endcase
                    end
                end
            end
            CMD_SHUTDOWN: begin
                accepting_q = 1'b0;
                cand_q      = 1'b0;
                trans_q     = 1'b0;
            end
            default: begin
                clear_route_state();
                if (init_valid_q) begin
                    active_q     = 1'b1;
                    active_dev_q = init_id_q;
                    out_on_q     = 1'b1;
                end
                tr = trans_q;
            end
        endcase

        r.status_code   = st;
        r.generation    = gen_q;
        r.cand_valid    = cand_q;
        r.cand_sequence = cand_q ? cand_seq_q : '0;
        r.cand_device   = cand_q ? cand_dev_q : '0;
        r.cand_removal  = cand_q && cand_rm_q;
        r.active_valid  = active_q;
        r.active_device = active_q ? active_dev_q : '0;
        r.output_on     = out_on_q;
        r.in_transition = tr;
        r.last_sequence = last_seq_q;
        r.accepting     = accepting_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            if (err_total < 10) begin
                $display("result word %0d, %s: expected %h, got %h", words_taken, name, e, a);
            end
            err_total++;
        end
    endfunction

    function automatic void compare_word(out_word_t e, out_word_t a);
        check_field("status_code", 64'(e.status_code), 64'(a.status_code));
        check_field("generation", e.generation, a.generation);
        check_field("cand_valid", 64'(e.cand_valid), 64'(a.cand_valid));
        check_field("cand_sequence", e.cand_sequence, a.cand_sequence);
        check_field("cand_device", 64'(e.cand_device), 64'(a.cand_device));
        check_field("cand_removal", 64'(e.cand_removal), 64'(a.cand_removal));
        check_field("active_valid", 64'(e.active_valid), 64'(a.active_valid));
        check_field("active_device", 64'(e.active_device), 64'(a.active_device));
        check_field("output_on", 64'(e.output_on), 64'(a.output_on));
        check_field("in_transition", 64'(e.in_transition), 64'(a.in_transition));
        check_field("last_sequence", e.last_sequence, a.last_sequence);
        check_field("accepting", 64'(e.accepting), 64'(a.accepting));
    endfunction

    // Track register writes, compare result words, and predict accepted commands.
    always @(posedge aclk) begin
        if (!aresetn) begin
            init_valid_q = 1'b0;
            init_id_q    = '0;
            clear_route_state();
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_INIT_VALID) begin
                    init_valid_q = cfg_wr_data[0];
                end else begin
                    init_id_q = cfg_wr_data;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (err_total < 10) begin
                        $display("result word %0d arrived with none expected: %h",
                                 words_taken, m_data);
                    end
                    err_total++;
                end else begin
                    compare_word(expected_words.pop_front(), m_data);
                end
                words_taken++;
            end
            if (s_valid && s_ready) begin
                expected_words.insert(expected_words.size(), predict_route_word(s_data));
            end
        end
        words_outstanding <= expected_words.size();
        mismatch_count    <= err_total;
    end

endmodule

@@ tb/tb_output_route_change_controller.sv @@
`timescale 1ns / 1ps

module tb_output_route_change_controller
    import orcc_pkg::*;
();

    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 100000;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    in_word_t                 s_data      = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    out_word_t                m_data;
    logic                     cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;

    int words_outstanding;
    int mismatch_count;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_go = 1'b0;
    int hold_done = 0;
    int cycle_cnt = 0;

    // Stimulus bookkeeping: next fresh sequence and the last notified candidate.
    logic [SEQ_BITS-1:0]         seq_next      = '0;
    logic [SEQ_BITS-1:0]         last_seq_sent = '0;
    logic [DEVICE_PORT_BITS-1:0] last_dev_sent = '0;
    logic [DEVICE_PORT_BITS-1:0] cur_init_id   = '0;

    output_route_change_controller DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    route_state_checker route_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wr_data       (cfg_wr_data),
        .words_outstanding (words_outstanding),
        .mismatch_count    (mismatch_count)
    );

    always #6 aclk = ~aclk;

    // Result side: random stalls, plus one long hold-off once it is requested.
    always @(posedge aclk) begin
        if (hold_go && hold_done < HOLD_CYCLES) begin
            m_ready   <= 1'b0;
            hold_done <= hold_done + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_output_route_change_controller: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Every field starts random, so unused fields toggle too.
    function automatic in_word_t noise_word();
        in_word_t w;
        w.command          = 2'($urandom_range(0, 3));
        w.notify_seq       = rand64();
        w.event_device     = $urandom;
        w.event_is_removal = 1'($urandom_range(0, 1));
        w.outcome_code     = 2'($urandom_range(0, 3));
        w.outcome_sequence = rand64();
        w.outcome_device   = $urandom;
        w.old_resumed      = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic in_word_t plain_word(logic [1:0] cmd);
        in_word_t w;
        w         = noise_word();
        w.command = cmd;
        return w;
    endfunction

    function automatic in_word_t notify_word(logic [63:0] seq, logic [31:0] dev, logic rm);
        in_word_t w;
        w                  = plain_word(CMD_NOTIFY);
        w.notify_seq       = seq;
        w.event_device     = dev;
        w.event_is_removal = rm;
        return w;
    endfunction

    function automatic in_word_t outcome_word(logic [1:0] code, logic [63:0] seq,
                                              logic [31:0] dev, logic resumed);
        in_word_t w;
        w                  = plain_word(CMD_OUTCOME);
        w.outcome_code     = code;
        w.outcome_sequence = seq;
        w.outcome_device   = dev;
        w.old_resumed      = resumed;
        return w;
    endfunction

    // Mostly fresh notifications followed by outcomes for the latest candidate,
    // with stale sequences, random noise, occasional init and rare shutdown.
    function automatic in_word_t next_route_word();
        in_word_t w;
        int       pick;
        int       k;
        logic [31:0] dev;
        logic [1:0]  code;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, 9);
        if (k < 4) begin
            dev = $urandom_range(0, 3);
        end else if (k < 6) begin
            dev = last_dev_sent;
        end else if (k < 7) begin
            dev = cur_init_id;
        end else begin
            dev = $urandom;
        end
        if (pick < 48) begin
            seq_next      = seq_next + 64'($urandom_range(1, 4));
            last_seq_sent = seq_next;
            last_dev_sent = dev;
            w = notify_word(seq_next, dev, $urandom_range(0, 3) == 0);
        end else if (pick < 78) begin
            code = ($urandom_range(0, 1) == 0) ? OUTC_ACTIVE : 2'($urandom_range(0, 3));
            w = outcome_word(code, last_seq_sent, last_dev_sent,
                             1'($urandom_range(0, 1)));
        end else if (pick < 88) begin
            w = notify_word(last_seq_sent - 64'($urandom_range(0, 2)), dev,
                            1'($urandom_range(0, 1)));
        end else if (pick < 95) begin
            w = noise_word();
            w.command = ($urandom_range(0, 1) == 0) ? CMD_NOTIFY : CMD_OUTCOME;
            if (w.command == CMD_NOTIFY) begin
                seq_next     = seq_next + 64'($urandom);
                w.notify_seq = seq_next;
            end
        end else if (pick < 99) begin
            w        = plain_word(CMD_INIT);
            seq_next = rand64() >> 2;
        end else begin
            w = plain_word(CMD_SHUTDOWN);
        end
        return w;
    endfunction

    // Offer one word; valid stays up across back-to-back words.
    task automatic send_word(in_word_t w);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both registers; the valid register carries random upper bits.
    task automatic set_init_device(logic v, logic [31:0] id);
        logic [31:0] data;
        data        = $urandom;
        data[0]     = v;
        cur_init_id = id;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_INIT_VALID;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_addr    <= CFG_INIT_ID;
        cfg_wr_data <= id;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(int count, int hold_at);
        send_word(plain_word(CMD_INIT));
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_go <= 1'b1;
            end
            send_word(next_route_word());
        end
    endtask

    initial begin
        tx_idle_pct = 13;
        rx_idle_pct = 50;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_init_device(1'b1, 32'hFFFF_FFFF);

        // Directed walk through every status and the extremes of the fields.
        send_word(outcome_word(OUTC_ACTIVE, '0, '0, 1'b1));
        send_word(plain_word(CMD_INIT));
        send_word(notify_word('0, 32'hFFFF_FFFF, 1'b0));
        send_word(notify_word('0, 32'hFFFF_FFFF, 1'b0));
        send_word(notify_word(64'd1, '0, 1'b0));
        send_word(notify_word(64'd2, '0, 1'b0));
        send_word(outcome_word(OUTC_ACTIVE, 64'd1, '0, 1'b0));
        send_word(outcome_word(OUTC_ACTIVE, 64'd2, '0, 1'b1));
        send_word(notify_word(64'd3, '0, 1'b1));
        send_word(outcome_word(OUTC_FAILED, 64'd3, '0, 1'b1));
        send_word(notify_word(64'd4, 32'h1234_5678, 1'b0));
        send_word(outcome_word(OUTC_LOST, 64'd4, 32'h1234_5678, 1'b0));
        send_word(notify_word(64'd5, 32'd5, 1'b0));
        send_word(outcome_word(OUTC_NO_OUTPUT, 64'd5, 32'd5, 1'b0));
        send_word(notify_word('1, 32'd7, 1'b1));
        send_word(notify_word('1, 32'd7, 1'b0));
        send_word(outcome_word(OUTC_ACTIVE, '1, 32'd8, 1'b0));
        send_word(plain_word(CMD_SHUTDOWN));
        send_word(notify_word('1, 32'd9, 1'b0));
        send_word(outcome_word(OUTC_ACTIVE, '1, 32'd7, 1'b0));
        send_word(plain_word(CMD_SHUTDOWN));
        send_word(plain_word(CMD_INIT));
        send_word(outcome_word(OUTC_ACTIVE, '0, '0, 1'b0));
        send_word(notify_word('0, 32'hFFFF_FFFF, 1'b1));
        send_word(outcome_word(OUTC_ACTIVE, '0, 32'hFFFF_FFFF, 1'b0));
        wait_idle();

        // Random phases under changing stall patterns and register settings.
        set_init_device(1'b0, '0);
        seq_next = rand64() >> 2;
        run_random(180, -1);
        wait_idle();

        tx_idle_pct = 50;
        rx_idle_pct = 13;
        set_init_device(1'b1, $urandom);
        run_random(180, -1);
        wait_idle();

        // No idling; the receiver holds off for a while so the input backs up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_init_device(1'b1, '0);
        run_random(180, 40);
        wait_idle();

        if (mismatch_count == 0 && words_outstanding == 0) begin
            $display("tb_output_route_change_controller: clean");
        end else begin
            $display("tb_output_route_change_controller: errors");
        end
        $finish;
    end

endmodule
